// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: the transaction
// payloads, operation codes, control characters and reset values.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int ROWS_DEF     = 25;
    localparam int COLS_DEF     = 80;
    localparam int TAB_STOP_DEF = 4;

    // Operation codes carried in the mode field.
    localparam logic [2:0] MODE_PUT    = 3'd0;
    localparam logic [2:0] MODE_SETCUR = 3'd1;
    localparam logic [2:0] MODE_CLEAR  = 3'd2;
    localparam logic [2:0] MODE_SCROLL = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    // Control characters and the blank character.
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [3:0]  FG_RESET    = 4'd7;
    localparam logic [3:0]  BG_RESET    = 4'd0;
    localparam logic [15:0] RESET_BLANK = {BG_RESET, FG_RESET, CH_SPACE};

    // Register indexes, decoded from address bit 2.
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] char_code;
        logic [7:0] row_sel;
        logic [7:0] col_sel;
        logic [7:0] line_count;
    } tcw_in_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [15:0] cell_data;
    } tcw_out_t;

endpackage

// ===== sv/tcw_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Screen cell store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
    parameter int DEPTH = tcw_pkg::ROWS_DEF * tcw_pkg::COLS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [15:0]       wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [15:0]       rdata
);

    logic [15:0] mem_reg [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Operation sequencer: cursor state, a compare-subtract unit for the modulo
// reductions, the cell walk used by clear and scroll, and the result register.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int COLS     = tcw_pkg::COLS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF,
    localparam int ADDR_W  = $clog2(ROWS * COLS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tcw_pkg::tcw_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tcw_pkg::tcw_out_t m_data,
    input  logic [7:0]        attr,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [15:0]       mem_wdata,
    output logic [ADDR_W-1:0] mem_raddr,
    input  logic [15:0]       mem_rdata
);

    localparam int NCELLS = ROWS * COLS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int PH_W   = $clog2(TAB_STOP + 1);

    localparam logic [ADDR_W:0]   OFF_ALL   = (ADDR_W+1)'(NCELLS);
    localparam logic [ADDR_W:0]   OFF_LINE  = (ADDR_W+1)'(COLS);
    localparam logic [ADDR_W:0]   COLS_A    = (ADDR_W+1)'(COLS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(NCELLS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]    COLS_W    = (COL_W+1)'(COLS);
    localparam logic [7:0]        ROWS_B    = 8'(ROWS);
    localparam logic [7:0]        COLS_B    = 8'(COLS);
    localparam logic [7:0]        TAB_B     = 8'(TAB_STOP);
    localparam logic [PH_W-1:0]   TAB_LAST  = PH_W'(TAB_STOP - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MOD    = 4'd1;
    localparam logic [3:0] S_EMIT   = 4'd2;
    localparam logic [3:0] S_WALK   = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_READ   = 4'd5;
    localparam logic [3:0] S_RDWAIT = 4'd6;
    localparam logic [3:0] S_FINISH = 4'd7;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_NL   = 2'd1;
    localparam logic [1:0] KIND_CR   = 2'd2;
    localparam logic [1:0] KIND_TAB  = 2'd3;

    logic [3:0]        state_reg, state_next;
    logic              init_reg, init_next;
    logic [2:0]        mode_reg, mode_next;
    logic [1:0]        kind_reg, kind_next;
    logic [7:0]        ch_reg, ch_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [7:0]        mod_row_reg, mod_row_next;
    logic [7:0]        mod_col_reg, mod_col_next;
    logic [7:0]        col_div_reg, col_div_next;
    logic [PH_W-1:0]   tab_ph_reg, tab_ph_next;
    logic [ADDR_W:0]   off_reg, off_next;
    logic [ADDR_W-1:0] wi_reg, wi_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              pend_copy_reg, pend_copy_next;
    logic [15:0]       data_reg, data_next;
    logic              mval_reg, mval_next;
    tcw_pkg::tcw_out_t mdata_reg, mdata_next;

    logic [ADDR_W:0]   src;
    logic              src_copy;
    logic [15:0]       blank;
    logic [7:0]        emit_ch;
    logic [ADDR_W-1:0] cur_idx;
    logic [ADDR_W-1:0] mod_idx;
    logic              row_ge;
    logic              col_ge;
    logic [COL_W:0]    col_inc;
    logic              wrap;
    logic [PH_W-1:0]   ph_inc;
    logic [ROW_W-1:0]  row_fin;
    logic [ROW_W+4:0]  row_ext;
    logic [COL_W+6:0]  col_ext;

    // The walk writes cell wi from cell wi + off in the cycle after reading it;
    // sources past the end of the store give blanks.
    assign src      = {1'b0, wi_reg} + off_reg;
    assign src_copy = src < OFF_ALL;
    assign blank    = init_reg ? tcw_pkg::RESET_BLANK : {attr, tcw_pkg::CH_SPACE};
    assign emit_ch  = (kind_reg == KIND_CHAR) ? ch_reg : tcw_pkg::CH_SPACE;
    assign cur_idx  = ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(COLS)) + ADDR_W'(col_reg);
    assign mod_idx  = ADDR_W'(ADDR_W'(mod_row_reg[ROW_W-1:0]) * ADDR_W'(COLS))
                    + ADDR_W'(mod_col_reg[COL_W-1:0]);
    assign row_ge   = mod_row_reg >= ROWS_B;
    assign col_ge   = mod_col_reg >= col_div_reg;
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign wrap     = col_inc == COLS_W;
    assign ph_inc   = (tab_ph_reg == TAB_LAST) ? '0 : tab_ph_reg + 1'b1;
    assign row_fin  = (kind_reg == KIND_CR && row_reg != '0) ? row_reg - 1'b1 : row_reg;
    assign row_ext  = {5'd0, row_fin};
    assign col_ext  = {7'd0, col_reg};

    assign mem_we    = pend_valid_reg || (state_reg == S_EMIT);
    assign mem_waddr = pend_valid_reg ? pend_addr_reg : cur_idx;
    assign mem_wdata = pend_valid_reg ? (pend_copy_reg ? mem_rdata : blank)
                                      : {attr, emit_ch};
    assign mem_raddr = (state_reg == S_READ) ? mod_idx : src[ADDR_W-1:0];

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mval_reg;
    assign m_data  = mdata_reg;

    always_comb begin
        state_next      = state_reg;
        init_next       = init_reg;
        mode_next       = mode_reg;
        kind_next       = kind_reg;
        ch_next         = ch_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        mod_row_next    = mod_row_reg;
        mod_col_next    = mod_col_reg;
        col_div_next    = col_div_reg;
        tab_ph_next     = tab_ph_reg;
        off_next        = off_reg;
        wi_next         = wi_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_copy_next  = pend_copy_reg;
        data_next       = data_reg;
        mval_next       = mval_reg;
        mdata_next      = mdata_reg;

        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next = s_data.mode;
                    kind_next = KIND_CHAR;
                    ch_next   = s_data.char_code;
                    data_next = '0;
                    wi_next   = '0;
                    unique case (s_data.mode)
                        tcw_pkg::MODE_PUT: begin
                            priority if (s_data.char_code == tcw_pkg::CH_NL) begin
                                kind_next  = KIND_NL;
                                state_next = S_EMIT;
                            end else if (s_data.char_code == tcw_pkg::CH_CR) begin
                                kind_next  = KIND_CR;
                                col_next   = '0;
                                state_next = S_EMIT;
                            end else if (s_data.char_code == tcw_pkg::CH_TAB) begin
                                // Find the tab phase of the current column first.
                                kind_next    = KIND_TAB;
                                mod_row_next = '0;
                                mod_col_next = 8'(col_reg);
                                col_div_next = TAB_B;
                                state_next   = S_MOD;
                            end else begin
                                state_next = S_EMIT;
                            end
                        end
                        tcw_pkg::MODE_SETCUR, tcw_pkg::MODE_READ: begin
                            mod_row_next = s_data.row_sel;
                            mod_col_next = s_data.col_sel;
                            col_div_next = COLS_B;
                            state_next   = S_MOD;
                        end
                        tcw_pkg::MODE_CLEAR: begin
                            row_next   = '0;
                            col_next   = '0;
                            off_next   = OFF_ALL;
                            state_next = S_WALK;
                        end
                        tcw_pkg::MODE_SCROLL: begin
                            priority if (s_data.line_count == '0) begin
                                state_next = S_FINISH;
                            end else if (s_data.line_count >= ROWS_B) begin
                                row_next   = '0;
                                col_next   = '0;
                                off_next   = OFF_ALL;
                                state_next = S_WALK;
                            end else begin
                                off_next   = (ADDR_W+1)'((ADDR_W+1)'(
                                             s_data.line_count[ROW_W-1:0]) * COLS_A);
                                state_next = S_WALK;
                            end
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_MOD: begin
                if (row_ge) begin
                    mod_row_next = mod_row_reg - ROWS_B;
                end
                if (col_ge) begin
                    mod_col_next = mod_col_reg - col_div_reg;
                end
                if (!row_ge && !col_ge) begin
                    unique case (mode_reg)
                        tcw_pkg::MODE_SETCUR: begin
                            row_next   = mod_row_reg[ROW_W-1:0];
                            col_next   = mod_col_reg[COL_W-1:0];
                            state_next = S_FINISH;
                        end
                        tcw_pkg::MODE_READ: begin
                            state_next = S_READ;
                        end
                        default: begin
                            tab_ph_next = PH_W'(mod_col_reg);
                            state_next  = S_EMIT;
                        end
                    endcase
                end
            end

            S_EMIT: begin
                if (wrap) begin
                    // A wrap lands on column 0, which ends every fill loop.
                    col_next = '0;
                    if (row_reg == LAST_ROW) begin
                        off_next   = OFF_LINE;
                        wi_next    = '0;
                        state_next = S_WALK;
                    end else begin
                        row_next   = row_reg + 1'b1;
                        state_next = S_FINISH;
                    end
                end else begin
                    col_next    = col_inc[COL_W-1:0];
                    tab_ph_next = ph_inc;
                    unique case (kind_reg)
                        KIND_NL, KIND_CR: state_next = S_EMIT;
                        KIND_TAB: state_next = (ph_inc == '0) ? S_FINISH : S_EMIT;
                        default:  state_next = S_FINISH;
                    endcase
                end
            end

            S_WALK: begin
                pend_valid_next = 1'b1;
                pend_addr_next  = wi_reg;
                pend_copy_next  = src_copy;
                if (wi_reg == LAST_CELL) begin
                    state_next = S_DRAIN;
                end else begin
                    wi_next = wi_reg + 1'b1;
                end
            end

            S_DRAIN: begin
                if (init_reg) begin
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_FINISH;
                end
            end

            S_READ: begin
                state_next = S_RDWAIT;
            end

            S_RDWAIT: begin
                data_next  = mem_rdata;
                state_next = S_FINISH;
            end

            S_FINISH: begin
                if (!mval_reg || m_ready) begin
                    row_next              = row_fin;
                    kind_next             = KIND_CHAR;
                    mval_next             = 1'b1;
                    mdata_next.cursor_row = row_ext[4:0];
                    mdata_next.cursor_col = col_ext[6:0];
                    mdata_next.cell_data  = data_reg;
                    state_next            = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_WALK;
            init_reg       <= 1'b1;
            kind_reg       <= KIND_CHAR;
            row_reg        <= '0;
            col_reg        <= '0;
            off_reg        <= OFF_ALL;
            wi_reg         <= '0;
            pend_valid_reg <= 1'b0;
            mval_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            init_reg       <= init_next;
            kind_reg       <= kind_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            off_reg        <= off_next;
            wi_reg         <= wi_next;
            pend_valid_reg <= pend_valid_next;
            mval_reg       <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        ch_reg        <= ch_next;
        mod_row_reg   <= mod_row_next;
        mod_col_reg   <= mod_col_next;
        col_div_reg   <= col_div_next;
        tab_ph_reg    <= tab_ph_next;
        pend_addr_reg <= pend_addr_next;
        pend_copy_reg <= pend_copy_next;
        data_reg      <= data_next;
        mdata_reg     <= mdata_next;
    end

endmodule

// ===== sv/text_console_writer.sv =====
// Sequence: a printable character passes the emit and finish states before m_valid. Newline
// and return write one blank per cycle (up to COLS). Tab first finds its column's tab phase in the
// compare-subtract unit, where set cursor and read also reduce their row and column before acting.
// Clear, a nonzero scroll and a wrap off the last row each walk all ROWS*COLS cells, one per cycle.
// Throughput: one transaction at a time, with s_ready low until the result is loaded.
// Reset: sync, active low; a walk over all cells then fills 0x0720 while s_ready stays low.
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine with a cell store, cursor and APB color registers.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int COLS     = tcw_pkg::COLS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tcw_pkg::tcw_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tcw_pkg::tcw_out_t m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int ADDR_W = $clog2(ROWS * COLS);

    logic [3:0]        fg_reg, fg_next;
    logic [3:0]        bg_reg, bg_next;
    logic              wr_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_rdata;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (wr_en) begin
            if (paddr[2] == tcw_pkg::REG_BG) begin
                bg_next = pwdata[3:0];
            end else begin
                fg_next = pwdata[3:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= tcw_pkg::FG_RESET;
            bg_reg <= tcw_pkg::BG_RESET;
        end else begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

    assign prdata = (paddr[2] == tcw_pkg::REG_FG) ? {28'd0, fg_reg} : {28'd0, bg_reg};

    tcw_cell_ram #(
        .DEPTH (ROWS * COLS)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcw_ctrl #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .TAB_STOP (TAB_STOP)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .attr      ({bg_reg, fg_reg}),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

// ===== sv/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input tcw_pkg::tcw_out_t m_data
);

    logic [1:0] open_reg, open_next;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    // Transactions accepted whose result has not been taken yet.
    always_comb begin
        open_next = open_reg;
        if (s_acc && !m_acc) begin
            open_next = open_reg + 1'b1;
        end else if (m_acc && !s_acc) begin
            open_next = open_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_next;
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_ready)
        else $error("input accepted again right after a transaction");

    a_init_not_ready: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("ready during the clearing pass after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_data.cursor_row) < ROWS) && (int'(m_data.cursor_col) < COLS))
        else $error("cursor outside the screen");

    a_no_extra_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> open_reg != '0)
        else $error("result without an accepted transaction");

endmodule

bind text_console_writer tcw_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer. A behavioral copy of
// the console (cell store, cursor and colors) predicts the outcome of every
// accepted command, and each result transaction is compared against it.
// The directed part covers the edge cases: wrap, scroll at the bottom row,
// control characters, scroll extremes and ignored modes. The random part
// places the cursor, writes short strings and reads them back, under several
// color settings, with random gaps on the command side and back-pressure on
// the result side.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SCR_ROWS     = tcw_pkg::ROWS_DEF;
    localparam int SCR_COLS     = tcw_pkg::COLS_DEF;
    localparam int SCR_TAB      = tcw_pkg::TAB_STOP_DEF;
    localparam int SCR_CELLS    = SCR_ROWS * SCR_COLS;
    localparam int SETTLE_CYC   = 64;
    localparam int LIMIT_CYCLES = 1_500_000;

    typedef enum {RX_STEADY, RX_RANDOM, RX_BURSTY} rx_style_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_valid  = 1'b0;
    logic              s_ready;
    tcw_pkg::tcw_in_t  s_data   = '0;
    logic              m_valid;
    logic              m_ready  = 1'b0;
    tcw_pkg::tcw_out_t m_data;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [2:0]        paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    text_console_writer u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the console.
    logic [15:0] screen_mem [0:SCR_CELLS-1];
    int          cur_row_q;
    int          cur_col_q;
    logic [3:0]  fg_q;
    logic [3:0]  bg_q;

    tcw_pkg::tcw_in_t  queued_cmds[$];
    tcw_pkg::tcw_out_t pending_reports[$];

    int n_accepted = 0;
    int n_checked  = 0;
    int n_reads    = 0;
    int n_settings = 1;
    int n_errors   = 0;
    int cycle_count = 0;
    logic s_took = 1'b0;

    // ------------------------------------------------------------------
    // Console predictor
    // ------------------------------------------------------------------
    function automatic logic [15:0] blank_cell();
        return {bg_q, fg_q, tcw_pkg::CH_SPACE};
    endfunction

    function automatic void clear_screen();
        for (int i = 0; i < SCR_CELLS; i++) screen_mem[i] = blank_cell();
        cur_row_q = 0;
        cur_col_q = 0;
    endfunction

    function automatic void scroll_up(input int lines);
        if (lines >= SCR_ROWS) begin
            clear_screen();
        end else if (lines > 0) begin
            for (int i = 0; i < (SCR_ROWS - lines) * SCR_COLS; i++)
                screen_mem[i] = screen_mem[i + lines * SCR_COLS];
            for (int i = (SCR_ROWS - lines) * SCR_COLS; i < SCR_CELLS; i++)
                screen_mem[i] = blank_cell();
        end
    endfunction

    function automatic void emit_cell(input logic [7:0] ch);
        screen_mem[cur_row_q * SCR_COLS + cur_col_q] = {bg_q, fg_q, ch};
        cur_col_q++;
        if (cur_col_q >= SCR_COLS) begin
            cur_col_q = 0;
            cur_row_q++;
            if (cur_row_q >= SCR_ROWS) begin
                scroll_up(1);
                cur_row_q = SCR_ROWS - 1;
            end
        end
    endfunction

    function automatic void put_glyph(input logic [7:0] ch);
        case (ch)
            tcw_pkg::CH_NL: begin
                do emit_cell(tcw_pkg::CH_SPACE); while (cur_col_q != 0);
            end
            tcw_pkg::CH_CR: begin
                // The blanked line advances the cursor like a newline, then it
                // steps back up to the start of that line.
                cur_col_q = 0;
                do emit_cell(tcw_pkg::CH_SPACE); while (cur_col_q != 0);
                if (cur_row_q > 0) cur_row_q--;
            end
            tcw_pkg::CH_TAB: begin
                do emit_cell(tcw_pkg::CH_SPACE); while ((cur_col_q % SCR_TAB) != 0);
            end
            default: emit_cell(ch);
        endcase
    endfunction

    function automatic tcw_pkg::tcw_out_t console_apply(input tcw_pkg::tcw_in_t cmd);
        tcw_pkg::tcw_out_t res;
        logic [15:0] cell_val;
        cell_val = '0;
        case (cmd.mode)
            tcw_pkg::MODE_PUT:    put_glyph(cmd.char_code);
            tcw_pkg::MODE_SETCUR: begin
                cur_row_q = int'(cmd.row_sel) % SCR_ROWS;
                cur_col_q = int'(cmd.col_sel) % SCR_COLS;
            end
            tcw_pkg::MODE_CLEAR:  clear_screen();
            tcw_pkg::MODE_SCROLL: scroll_up(int'(cmd.line_count));
            tcw_pkg::MODE_READ:   cell_val = screen_mem[(int'(cmd.row_sel) % SCR_ROWS) * SCR_COLS
                                                        + int'(cmd.col_sel) % SCR_COLS];
            default: ;
        endcase
        res.cursor_row = cur_row_q[4:0];
        res.cursor_col = cur_col_q[6:0];
        res.cell_data  = cell_val;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Command builders
    // ------------------------------------------------------------------
    function automatic tcw_pkg::tcw_in_t make_cmd(input logic [2:0] mode);
        tcw_pkg::tcw_in_t cmd;
        logic [63:0]      raw;
        // Fields the operation does not use still carry random values.
        raw      = {$urandom(), $urandom()};
        cmd      = raw[$bits(tcw_pkg::tcw_in_t)-1:0];
        cmd.mode = mode;
        return cmd;
    endfunction

    function automatic void send_mode(input logic [2:0] mode);
        queued_cmds.push_back(make_cmd(mode));
    endfunction

    function automatic void send_put(input logic [7:0] ch);
        tcw_pkg::tcw_in_t cmd;
        cmd = make_cmd(tcw_pkg::MODE_PUT);
        cmd.char_code = ch;
        queued_cmds.push_back(cmd);
    endfunction

    function automatic void send_cursor(input logic [7:0] row, input logic [7:0] col);
        tcw_pkg::tcw_in_t cmd;
        cmd = make_cmd(tcw_pkg::MODE_SETCUR);
        cmd.row_sel = row;
        cmd.col_sel = col;
        queued_cmds.push_back(cmd);
    endfunction

    function automatic void send_read(input logic [7:0] row, input logic [7:0] col);
        tcw_pkg::tcw_in_t cmd;
        cmd = make_cmd(tcw_pkg::MODE_READ);
        cmd.row_sel = row;
        cmd.col_sel = col;
        queued_cmds.push_back(cmd);
    endfunction

    function automatic void send_scroll(input logic [7:0] lines);
        tcw_pkg::tcw_in_t cmd;
        cmd = make_cmd(tcw_pkg::MODE_SCROLL);
        cmd.line_count = lines;
        queued_cmds.push_back(cmd);
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0:       return tcw_pkg::CH_NL;
            1:       return tcw_pkg::CH_TAB;
            2:       return tcw_pkg::CH_CR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed strings: place the cursor, write, read back.
    function automatic void random_phase(input int target);
        int count;
        int len;
        int roll;
        logic [7:0] row;
        logic [7:0] col;
        count = 0;
        while (count < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                row = 8'($urandom_range(0, 255));
                col = 8'($urandom_range(0, 255));
                len = $urandom_range(1, 8);
                send_cursor(row, col);
                for (int j = 0; j < len; j++) send_put(pick_char());
                for (int j = 0; j < len; j++)
                    send_read(row, 8'(int'(col) % SCR_COLS + j));
                count += 1 + 2 * len;
            end else if (roll < 70) begin
                send_put(pick_char());
                count++;
            end else if (roll < 78) begin
                send_read(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                count++;
            end else if (roll < 84) begin
                send_cursor(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                count++;
            end else if (roll < 89) begin
                case ($urandom_range(0, 3))
                    0:       send_scroll(8'd0);
                    1:       send_scroll(8'($urandom_range(0, 255)));
                    default: send_scroll(8'($urandom_range(1, 3)));
                endcase
                count++;
            end else if (roll < 92) begin
                send_mode(tcw_pkg::MODE_CLEAR);
                count++;
            end else if (roll < 95) begin
                // Ignored operation codes; not counted.
                send_mode(3'(tcw_pkg::MODE_READ + $urandom_range(1, 3)));
            end else begin
                len = $urandom_range(2, 5);
                for (int j = 0; j < len; j++)
                    send_put(($urandom_range(0, 1) == 1) ? tcw_pkg::CH_NL : tcw_pkg::CH_CR);
                count += len;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Register writes and idle detection
    // ------------------------------------------------------------------
    task automatic write_color(input logic sel, input logic [3:0] val);
        logic [31:0] word;
        word      = $urandom();
        word[3:0] = val;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= word;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (sel == tcw_pkg::REG_FG) fg_q = word[3:0];
        else bg_q = word[3:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (queued_cmds.size() != 0 || s_valid || pending_reports.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
        wait_idle();
        write_color(tcw_pkg::REG_FG, fg);
        write_color(tcw_pkg::REG_BG, bg);
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and stimulus
    // ------------------------------------------------------------------
    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        fg_q = tcw_pkg::FG_RESET;
        bg_q = tcw_pkg::BG_RESET;
        clear_screen();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset colors.
        send_read(8'd0, 8'd0);
        send_read(8'd255, 8'd255);
        send_put(8'h41);
        send_put(8'hFF);
        send_put(8'h00);
        send_put(tcw_pkg::CH_TAB);
        send_put(tcw_pkg::CH_NL);
        send_read(8'd0, 8'd1);
        send_cursor(8'(SCR_ROWS - 1), 8'(SCR_COLS - 1));
        send_put(8'h5A);
        send_read(8'(SCR_ROWS - 2), 8'(SCR_COLS - 1));
        send_put(tcw_pkg::CH_CR);
        send_cursor(8'd255, 8'd255);
        send_put(tcw_pkg::CH_CR);
        send_cursor(8'd0, 8'(SCR_COLS - 1));
        send_put(tcw_pkg::CH_TAB);
        send_cursor(8'(SCR_ROWS - 1), 8'(SCR_COLS - 2));
        send_put(tcw_pkg::CH_NL);
        send_scroll(8'd0);
        send_scroll(8'd1);
        send_scroll(8'(SCR_ROWS - 1));
        send_cursor(8'd3, 8'd7);
        send_scroll(8'(SCR_ROWS));
        send_scroll(8'd255);
        send_mode(tcw_pkg::MODE_CLEAR);
        for (int k = 1; k <= 3; k++) send_mode(3'(tcw_pkg::MODE_READ + k));
        send_read(8'(SCR_ROWS - 1), 8'(SCR_COLS - 1));

        random_phase(25);
        set_colors(4'd15, 4'd15);
        random_phase(25);
        set_colors(4'd0, 4'd0);
        random_phase(25);
        set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        random_phase(25);

        wait_idle();
        $display("Ran %0d commands under %0d color settings.", n_accepted, n_settings);
        $display("%0d results checked, %0d of them cell reads.", n_checked, n_reads);
        if (n_errors == 0 && pending_reports.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results outstanding", n_errors,
                     pending_reports.size());
            $display("status: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Command driver: bursts of random length separated by random gaps.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_took) begin
            // Hold the current transaction until it is accepted.
        end else if (gap_left > 0) begin
            gap_left--;
            s_valid <= 1'b0;
        end else if (queued_cmds.size() != 0) begin
            s_data  <= queued_cmds.pop_front();
            s_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 16);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver back-pressure.
    // ------------------------------------------------------------------
    rx_style_t rx_style   = RX_STEADY;
    int        rx_count   = 0;
    int        stall_left = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_count++;
            if (rx_count % 300 == 0) rx_style = rx_style_t'($urandom_range(0, 2));
            case (rx_style)
                RX_STEADY: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_ready <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                        if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 20);
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge aclk) begin
        tcw_pkg::tcw_out_t want;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                pending_reports.push_back(console_apply(s_data));
                n_accepted++;
                if (s_data.mode == tcw_pkg::MODE_READ) n_reads++;
            end
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected result transaction, actual 0x%0h",
                             $time, m_data);
                    n_errors++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("cursor_row", 16'(want.cursor_row), 16'(m_data.cursor_row));
                    check_field("cursor_col", 16'(want.cursor_col), 16'(m_data.cursor_col));
                    check_field("cell_data", want.cell_data, m_data.cell_data);
                    n_checked++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                     pending_reports.size());
            $display("status: fail");
            $finish;
        end
    end

endmodule
